// ===== rtl/pidc_pkg.sv =====
// Shared types and constants for the PID controller with output clamp.
// Used by pidc_ctrl, pidc_dp and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

    localparam int DW     = 16;           // target, measured, drive, limits
    localparam int AW     = 48;           // integral accumulator
    localparam int GW     = 32;           // gains
    localparam int TW     = 16;           // step time
    localparam int EW     = DW + 1;       // error
    localparam int FW     = DW + 2;       // error difference
    localparam int MW     = FW - 1;       // magnitude of error difference
    localparam int QW     = MW + TW;      // quotient of the derivative
    localparam int XW     = EW + TW + 1;  // error times step time
    localparam int CHW    = 16;           // multiplier chunk
    localparam int NCH    = AW / CHW;     // chunks per product
    localparam int CW     = $clog2(NCH);
    localparam int PW     = GW + AW;      // full product magnitude
    localparam int SW     = AW + 1;       // sum of three terms
    localparam int VW     = SW - 16;      // drive before clamping
    localparam int RIW    = 3;            // register index
    localparam int CNTW   = 6;
    localparam int DIV_STEPS = QW;

    localparam logic [AW-1:0] TERM_MAX = 48'h3FFF_FFFF_FFFF;

    localparam logic [RIW-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [RIW-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [RIW-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [RIW-1:0] REG_OUT_LOW  = 3'd3;
    localparam logic [RIW-1:0] REG_OUT_HIGH = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_ADD, S_INT, S_DIV, S_MINIT, S_MSTEP, S_MSTORE, S_SUM, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        TERM_P, TERM_I, TERM_D
    } t_term;

    typedef struct packed {
        logic          load_in;
        logic          calc_err;
        logic          calc_add;
        logic          upd_int;
        logic          div_init;
        logic          div_step;
        logic          mul_init;
        logic          mul_step;
        logic [CW-1:0] chunk;
        t_term         term;
        logic          term_store;
        logic          calc_sum;
        logic          load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/pidc_ctrl.sv =====
// Sequencer for the PID step: walks the error, integral, divider,
// multiply and clamp phases. Depends on pidc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidc_ctrl import pidc_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state           r_state, n_state;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    t_term            r_term, n_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_term  <= TERM_P;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_term  <= n_term;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_term     = r_term;
        o_cmd      = '0;
        o_cmd.term = r_term;
        o_cmd.chunk = r_cnt[CW-1:0];
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.calc_add = 1'b1;
                n_state = S_INT;
            end
            S_INT: begin
                o_cmd.upd_int  = 1'b1;
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(DIV_STEPS - 1)) begin
                    n_term  = TERM_P;
                    n_state = S_MINIT;
                end
            end
            S_MINIT: begin
                o_cmd.mul_init = 1'b1;
                n_cnt   = '0;
                n_state = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(NCH - 1)) n_state = S_MSTORE;
            end
            S_MSTORE: begin
                o_cmd.term_store = 1'b1;
                unique case (r_term)
                    TERM_P: begin
                        n_term  = TERM_I;
                        n_state = S_MINIT;
                    end
                    TERM_I: begin
                        n_term  = TERM_D;
                        n_state = S_MINIT;
                    end
                    default: n_state = S_SUM;
                endcase
            end
            S_SUM: begin
                o_cmd.calc_sum = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("result loaded into a busy output register");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_ERR))
        else $error("accepted item did not start the sequence");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNTW'(DIV_STEPS)))
        else $error("divider ran past its step count");
    a_out_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after a result");
`endif

endmodule

`default_nettype wire

// ===== rtl/pidc_dp.sv =====
// Datapath of the PID step: configuration, state, restoring divider,
// chunked multiplier, term saturation, clamp and output register. Uses pidc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidc_dp import pidc_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [RIW-1:0]        i_cfg_index,
    input  wire [GW-1:0]         i_cfg_data,
    input  wire signed [DW-1:0]  i_target,
    input  wire signed [DW-1:0]  i_measured,
    input  wire [TW-1:0]         i_step_time,
    input  wire t_cmd            i_cmd,
    output t_status              o_status,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output logic signed [DW-1:0] o_drive,
    output logic                 o_clamped
);

    logic signed [GW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [DW-1:0] r_out_low, r_out_high;
    logic signed [AW-1:0] r_int;
    logic signed [EW-1:0] r_last;

    logic signed [DW-1:0] r_tgt, r_meas;
    logic [TW-1:0]        r_dt;
    logic signed [EW-1:0] r_err;
    logic signed [XW-1:0] r_add;
    logic signed [FW-1:0] r_diff;

    logic [QW-1:0]        r_dvd, r_quo;
    logic [TW-1:0]        r_rem;

    logic [GW-1:0]        r_ua;
    logic [AW-1:0]        r_ub;
    logic                 r_neg;
    logic [PW-1:0]        r_macc;

    logic signed [AW-1:0] r_tp, r_ti, r_td;
    logic signed [VW-1:0] r_val;

    logic                 r_ovalid;
    logic signed [DW-1:0] r_drive;
    logic                 r_clamped;

    // combinational helpers
    logic signed [SW-1:0] int_next;
    logic [FW-1:0]        diff_mag;
    logic [TW:0]          rem_sh;
    logic                 rem_ge;
    logic                 a_neg, b_neg;
    logic signed [GW-1:0] a_sel;
    logic [GW-1:0]        a_mag;
    logic [AW-1:0]        b_mag;
    logic [EW-1:0]        err_mag;
    logic [PW-1:0]        part;
    logic [PW-1:0]        scaled;
    logic [AW-1:0]        sat_mag;
    logic signed [AW-1:0] term_val;
    logic signed [SW-1:0] sum;
    logic signed [VW-1:0] hi_ext, lo_ext;

    assign o_status.out_free = !r_ovalid || !i_out_stall;
    assign o_out_valid = r_ovalid;
    assign o_drive     = r_drive;
    assign o_clamped   = r_clamped;

    always_comb begin
        int_next = {r_int[AW-1], r_int} + SW'(r_add);
        diff_mag = r_diff[FW-1] ? -r_diff : r_diff;
        rem_sh   = {r_rem, r_dvd[QW-1]};
        rem_ge   = (rem_sh >= {1'b0, r_dt});
        err_mag  = r_err[EW-1] ? -r_err : r_err;

        case (i_cmd.term)
            TERM_P: begin
                a_sel = r_gain_p;
                b_neg = r_err[EW-1];
                b_mag = AW'(err_mag);
            end
            TERM_I: begin
                a_sel = r_gain_i;
                b_neg = r_int[AW-1];
                b_mag = r_int[AW-1] ? AW'(-r_int) : AW'(r_int);
            end
            default: begin
                a_sel = r_gain_d;
                b_neg = r_diff[FW-1];
                // zero step time gives no derivative
                b_mag = (r_dt == '0) ? '0 : AW'(r_quo);
            end
        endcase
        a_neg = a_sel[GW-1];
        a_mag = a_neg ? -a_sel : a_sel;

        part = PW'(r_ua * r_ub[i_cmd.chunk*CHW +: CHW]) << (i_cmd.chunk * CHW);

        // integral term is divided by 2^16, rounding toward minus infinity, before its saturation
        if (i_cmd.term == TERM_I)
            scaled = r_neg ? ((r_macc + PW'(16'hFFFF)) >> 16) : (r_macc >> 16);
        else
            scaled = r_macc;
        sat_mag  = (scaled > PW'(TERM_MAX)) ? TERM_MAX : scaled[AW-1:0];
        term_val = r_neg ? -$signed(sat_mag) : $signed(sat_mag);

        sum    = SW'(r_tp) + SW'(r_ti) + SW'(r_td);
        hi_ext = VW'(r_out_high);
        lo_ext = VW'(r_out_low);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_out_low  <= {1'b1, {(DW-1){1'b0}}};
            r_out_high <= {1'b0, {(DW-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GAIN_P:   r_gain_p   <= i_cfg_data;
                REG_GAIN_I:   r_gain_i   <= i_cfg_data;
                REG_GAIN_D:   r_gain_d   <= i_cfg_data;
                REG_OUT_LOW:  r_out_low  <= i_cfg_data[DW-1:0];
                REG_OUT_HIGH: r_out_high <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int  <= '0;
            r_last <= '0;
        end else begin
            if (i_cmd.calc_add) r_last <= r_err;
            if (i_cmd.upd_int) begin
                // saturate on signed overflow
                if (int_next[SW-1] != int_next[SW-2])
                    r_int <= int_next[SW-1] ? {1'b1, {(AW-1){1'b0}}}
                                            : {1'b0, {(AW-1){1'b1}}};
                else
                    r_int <= int_next[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_tgt  <= i_target;
            r_meas <= i_measured;
            r_dt   <= i_step_time;
        end
        if (i_cmd.calc_err) r_err <= EW'(r_tgt) - EW'(r_meas);
        if (i_cmd.calc_add) begin
            r_add  <= XW'(r_err * $signed({1'b0, r_dt}));
            r_diff <= FW'(r_err) - FW'(r_last);
        end
        if (i_cmd.div_init) begin
            r_dvd <= {diff_mag[MW-1:0], {TW{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= rem_ge ? TW'(rem_sh - {1'b0, r_dt}) : rem_sh[TW-1:0];
            r_quo <= {r_quo[QW-2:0], rem_ge};
        end
        if (i_cmd.mul_init) begin
            r_ua   <= a_mag;
            r_ub   <= b_mag;
            r_neg  <= a_neg ^ b_neg;
            r_macc <= '0;
        end else if (i_cmd.mul_step) begin
            r_macc <= r_macc + part;
        end
        if (i_cmd.term_store) begin
            case (i_cmd.term)
                TERM_P:  r_tp <= term_val;
                TERM_I:  r_ti <= term_val;
                default: r_td <= term_val;
            endcase
        end
        if (i_cmd.calc_sum) r_val <= sum[SW-1:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_val > hi_ext) begin
                r_drive   <= r_out_high;
                r_clamped <= 1'b1;
            end else if (r_val < lo_ext) begin
                r_drive   <= r_out_low;
                r_clamped <= 1'b1;
            end else begin
                r_drive   <= r_val[DW-1:0];
                r_clamped <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pid_controller_with_output_clamp.sv =====
// Positional PID step with clamped output: one result per item.
// The next item is taken only once the previous result has been loaded into
// the output register; each item runs the 33-step divider and
// three 3-chunk multiplies on one shared 32x16 multiplier.
// Reset (synchronous, active low) clears the integral, the stored error and
// the gains, and sets the output limits to the full signed range.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_with_output_clamp import pidc_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [RIW-1:0]        i_cfg_index,
    input  wire [GW-1:0]         i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire signed [DW-1:0]  i_target,
    input  wire signed [DW-1:0]  i_measured,
    input  wire [TW-1:0]         i_step_time,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic signed [DW-1:0] o_drive,
    output logic                 o_clamped
);

    t_cmd    cmd;
    t_status status;

    pidc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pidc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_target    (i_target),
        .i_measured  (i_measured),
        .i_step_time (i_step_time),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_drive     (o_drive),
        .o_clamped   (o_clamped)
    );

endmodule

`default_nettype wire

// ===== verif/pidc_checker.sv =====
// Checker for the PID controller: watches the config port and both item
// channels, predicts drive and clamp flag, and counts mismatches.
// Depends on pidc_pkg for widths and register indexes.
`timescale 1ns / 1ps

module pidc_checker import pidc_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [RIW-1:0]        i_cfg_index,
    input  wire [GW-1:0]         i_cfg_data,
    input  wire                  i_in_valid,
    input  wire                  i_in_stall,
    input  wire signed [DW-1:0]  i_target,
    input  wire signed [DW-1:0]  i_measured,
    input  wire [TW-1:0]         i_step_time,
    input  wire                  i_out_valid,
    input  wire                  i_out_stall,
    input  wire signed [DW-1:0]  i_drive,
    input  wire                  i_clamped,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic                 clamped;
    } t_drive_item;

    localparam longint unsigned TERM_LIM = 64'h0000_3FFF_FFFF_FFFF;
    localparam longint unsigned PROD_LIM = 64'h4000_0000_0000_0000;
    localparam longint ACC_MAX = (64'sd1 <<< (AW - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    logic signed [GW-1:0] kp, ki, kd;
    logic signed [DW-1:0] lim_low, lim_high;
    longint               integ;
    longint               held_err;
    t_drive_item          drive_q[$];

    function automatic longint unsigned magnitude(longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    function automatic longint sat_product(longint a, longint b, longint unsigned lim);
        longint unsigned ua, ub, m;
        ua = magnitude(a);
        ub = magnitude(b);
        if (ua != 0 && ub > lim / ua)
            m = lim;
        else
            m = ua * ub;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat_term(longint v);
        if (v > longint'(TERM_LIM)) return longint'(TERM_LIM);
        if (v < -longint'(TERM_LIM)) return -longint'(TERM_LIM);
        return v;
    endfunction

    // Advance integral and stored error, return the expected item.
    function automatic t_drive_item pid_step(longint tgt, longint meas, longint dt);
        longint err, add, diff, deriv, p, it, d, v;
        longint unsigned q;
        t_drive_item r;
        err = tgt - meas;
        add = err * dt;
        if (add > 0 && integ > ACC_MAX - add)
            integ = ACC_MAX;
        else if (add < 0 && integ < ACC_MIN - add)
            integ = ACC_MIN;
        else
            integ = integ + add;
        diff = err - held_err;
        if (dt == 0) begin
            deriv = 0;
        end else begin
            q = (magnitude(diff) << 16) / longint'(dt);
            deriv = (diff < 0) ? -longint'(q) : longint'(q);
        end
        p  = sat_product(longint'(kp), err, TERM_LIM);
        it = sat_term(sat_product(longint'(ki), integ, PROD_LIM) >>> 16);
        d  = sat_product(longint'(kd), deriv, TERM_LIM);
        v  = (p + it + d) >>> 16;
        r.clamped = 1'b0;
        if (v > longint'(lim_high)) begin
            v = lim_high;
            r.clamped = 1'b1;
        end else if (v < longint'(lim_low)) begin
            v = lim_low;
            r.clamped = 1'b1;
        end
        r.drive = v[DW-1:0];
        held_err = err;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_drive_item want;
        if (!i_rst_n) begin
            kp = '0;
            ki = '0;
            kd = '0;
            lim_low = {1'b1, {(DW-1){1'b0}}};
            lim_high = {1'b0, {(DW-1){1'b1}}};
            integ = 0;
            held_err = 0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN_P:   kp = i_cfg_data;
                    REG_GAIN_I:   ki = i_cfg_data;
                    REG_GAIN_D:   kd = i_cfg_data;
                    REG_OUT_LOW:  lim_low = i_cfg_data[DW-1:0];
                    REG_OUT_HIGH: lim_high = i_cfg_data[DW-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                drive_q.push_back(pid_step(i_target, i_measured, i_step_time));
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected item: drive %0d clamped %0b", i_drive, i_clamped);
                end else begin
                    want = drive_q.pop_front();
                    if (want.drive !== i_drive || want.clamped !== i_clamped) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: drive exp %0d got %0d, clamped exp %0b got %0b",
                                     want.drive, i_drive, want.clamped, i_clamped);
                    end
                end
            end
        end
        o_pending = drive_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

endmodule

// ===== verif/tb_pid_controller_with_output_clamp.sv =====
// Testbench top for the PID controller: clock, reset, config phases and
// item stimulus with random gaps and stalls; pidc_checker does the checking.
// Depends on pidc_pkg, pidc_checker and the RTL top.
`timescale 1ns / 1ps

module tb_pid_controller_with_output_clamp;
    import pidc_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [RIW-1:0]       cfg_index = '0;
    logic [GW-1:0]        cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [DW-1:0] target = '0;
    logic signed [DW-1:0] measured = '0;
    logic [TW-1:0]        step_time = 16'd1;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [DW-1:0] drive;
    logic                 clamped;
    int                   errors, pending;
    bit                   calm = 1'b0;
    int                   stall_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    pid_controller_with_output_clamp i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_target(target), .i_measured(measured), .i_step_time(step_time),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_drive(drive), .o_clamped(clamped)
    );

    pidc_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_target(target), .i_measured(measured), .i_step_time(step_time),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_drive(drive), .i_clamped(clamped),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver: after each accepted item, stall for a random count of cycles.
    always @(posedge i_clk) begin
        int nxt;
        nxt = stall_left;
        if (nxt > 0)
            nxt--;
        else if (out_valid && !out_stall)
            nxt = calm ? 0 : $urandom_range(0, 4);
        stall_left <= nxt;
        out_stall <= (nxt != 0);
    end

    task automatic write_reg(logic [RIW-1:0] idx, logic [GW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        if (in_valid) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_item(logic signed [DW-1:0] t, logic signed [DW-1:0] m,
                             logic [TW-1:0] dt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        target <= t;
        measured <= m;
        step_time <= dt;
        do @(posedge i_clk); while (in_stall);
    endtask

    function automatic logic [GW-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return 32'(int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
            default: return 32'(int'($urandom_range(0, 32'h0000_2000)) - 32'h0000_1000);
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_dt();
        case ($urandom_range(0, 3))
            0: return TW'($urandom_range(1, 16));
            1: return 16'hFFFF;
            default: return TW'($urandom_range(1, 16'hFFFF));
        endcase
    endfunction

    task automatic random_phase(int count);
        logic signed [DW-1:0] lo, hi;
        drain();
        write_reg(REG_GAIN_P, pick_gain());
        write_reg(REG_GAIN_I, pick_gain());
        write_reg(REG_GAIN_D, pick_gain());
        lo = DW'($urandom());
        hi = DW'($urandom());
        case ($urandom_range(0, 3))
            0: begin lo = -16'sd32768; hi = 16'sd32767; end
            1: hi = lo;
            2: ;
            default: if (lo > hi) begin lo = hi; hi = DW'($urandom()); end
        endcase
        write_reg(REG_OUT_LOW, 32'(lo));
        write_reg(REG_OUT_HIGH, 32'(hi));
        calm = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) == 0)
                send_item(DW'($urandom()), DW'($urandom()), pick_dt());
            else
                send_item(16'(int'($urandom_range(0, 400)) - 200),
                          16'(int'($urandom_range(0, 400)) - 200), pick_dt());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains: everything should come out as zero drive.
        send_item(16'sd100, -16'sd100, 16'd1000);
        drain();
        write_reg(REG_GAIN_P, 32'h0001_0000);
        write_reg(REG_GAIN_I, 32'h0000_8000);
        write_reg(REG_GAIN_D, 32'h0000_0100);
        write_reg(REG_OUT_LOW, 32'(-16'sd1000));
        write_reg(REG_OUT_HIGH, 32'(16'sd1000));
        send_item(16'sd32767, -16'sd32768, 16'd1);
        send_item(16'sd32767, -16'sd32768, 16'hFFFF);
        send_item(-16'sd32768, 16'sd32767, 16'd1);
        send_item(-16'sd32768, 16'sd32767, 16'hFFFF);
        send_item(16'sd0, 16'sd0, 16'd1);
        send_item(16'sd5, 16'sd3, 16'd2);
        send_item(-16'sd7, 16'sd9, 16'hFFFF);
        send_item(16'sd0, 16'sd0, 16'h8000);
        send_item(16'h5555, 16'hAAAA, 16'h5555);
        send_item(16'hAAAA, 16'h5555, 16'hAAAA);
        // Push large integral steps in both directions.
        repeat (6) send_item(16'sd32767, -16'sd32768, 16'hFFFF);
        repeat (6) send_item(-16'sd32768, 16'sd32767, 16'hFFFF);

        // Extreme gains with inverted limits: clamp order decides.
        drain();
        write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_I, 32'h8000_0000);
        write_reg(REG_GAIN_D, 32'h7FFF_FFFF);
        write_reg(REG_OUT_LOW, 32'(16'sd500));
        write_reg(REG_OUT_HIGH, 32'(-16'sd500));
        send_item(16'sd1, 16'sd0, 16'd1);
        send_item(-16'sd1, 16'sd0, 16'd1);
        send_item(16'sd0, 16'sd0, 16'd1);
        drain();
        write_reg(3'd7, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 8; ph++) begin
            random_phase(80);
            // Hold the sender until every outstanding result is back.
            if (ph == 3) drain();
        end

        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
